/* hdl/mtbri_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, command and status types and helper functions for the
// bounded random integer block. No dependencies.
package mtbri_pkg;

  localparam int unsigned NWORDS  = 624;
  localparam int unsigned MSHIFT  = 397;
  localparam int unsigned IDX_W   = 10;
  localparam logic [31:0] MATRIX      = 32'h9908b0df;
  localparam logic [31:0] UPPER       = 32'h80000000;
  localparam logic [31:0] LOWER       = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc60000;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NWORDS - 1);

  // Read address selection for the state memory
  localparam logic [1:0] RD_CUR  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_FAR  = 2'd2;

  typedef struct packed {
    logic       seed_start;
    logic       seed_cfg;
    logic       seed_step;
    logic       load;
    logic       span;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_hi;
    logic       cap_lo;
    logic       mix;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic seed_last;
    logic span_zero;
    logic reject;
  } stat_t;

  function automatic logic [31:0] tw_mix(input logic [31:0] hi, input logic [31:0] lo,
                                         input logic [31:0] far);
    logic [31:0] y;
    y = (hi & UPPER) | (lo & LOWER);
    return far ^ (y >> 1) ^ (y[0] ? MATRIX : 32'h0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* hdl/mtbri_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences seeding, draws and handshakes.
// Depends on mtbri_pkg.
module mtbri_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  mtbri_pkg::stat_t stat_i,
  output mtbri_pkg::ctrl_t ctrl_o
);

  localparam logic [3:0] ST_SEED0 = 4'd0;
  localparam logic [3:0] ST_SEED  = 4'd1;
  localparam logic [3:0] ST_IDLE  = 4'd2;
  localparam logic [3:0] ST_SPAN  = 4'd3;
  localparam logic [3:0] ST_RA    = 4'd4;
  localparam logic [3:0] ST_RB    = 4'd5;
  localparam logic [3:0] ST_RC    = 4'd6;
  localparam logic [3:0] ST_MIX   = 4'd7;
  localparam logic [3:0] ST_CHK   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEED0;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_SEED0: begin
        ctrl_o.seed_start = 1'b1;
        state_d = ST_SEED;
      end
      ST_SEED: begin
        ctrl_o.seed_step = 1'b1;
        if (stat_i.seed_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_valid_i) begin
          ctrl_o.seed_start = 1'b1;
          ctrl_o.seed_cfg   = 1'b1;
          state_d = ST_SEED;
        end else if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        ctrl_o.span = 1'b1;
        state_d = stat_i.span_zero ? ST_DONE : ST_RA;
      end
      ST_RA: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = mtbri_pkg::RD_CUR;
        state_d = ST_RB;
      end
      ST_RB: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = mtbri_pkg::RD_NEXT;
        ctrl_o.cap_hi = 1'b1;
        state_d = ST_RC;
      end
      ST_RC: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = mtbri_pkg::RD_FAR;
        ctrl_o.cap_lo = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        ctrl_o.mix = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = stat_i.reject ? ST_RA : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_SEED0;
    endcase
  end

endmodule

/* hdl/mtbri_dp.sv */
`timescale 1ns / 1ps
// Datapath: twister state memory, seeding recurrence, on-the-fly twist,
// tempering, rejection compare and result register. Depends on mtbri_pkg.
module mtbri_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtbri_pkg::ctrl_t   ctrl_i,
  output mtbri_pkg::stat_t   stat_o,
  input  logic [31:0]        cfg_data_i,
  input  logic [29:0]        bound_a_i,
  input  logic [29:0]        bound_b_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [30:0]        value_o
);

  localparam int unsigned IW = mtbri_pkg::IDX_W;

  logic [31:0]   mem_q [mtbri_pkg::NWORDS];
  logic [31:0]   rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [IW-1:0] idx_q, cnt_q;
  logic [31:0]   p_q, p_d, seed_v;
  logic [29:0]   a_q;
  logic [30:0]   span_q;
  logic [29:0]   mag_q, mask_q, r_q;
  logic          neg_q;
  logic [31:0]   hi_q, lo_q, mixed, tempered;
  logic [IW-1:0] idx_next, idx_far;
  logic [IW:0]   far_sum;
  logic [30:0]   mag_w;
  logic [29:0]   smear;
  logic [31:0]   off_w, sum_w;
  logic          out_valid_q;
  logic [30:0]   value_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (ctrl_i.rd_en) rd_q <= mem_q[rd_addr];
  end

  assign idx_next = (idx_q == mtbri_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
  assign far_sum  = {1'b0, idx_q} + (IW+1)'(mtbri_pkg::MSHIFT);
  assign idx_far  = (far_sum >= (IW+1)'(mtbri_pkg::NWORDS))
                    ? IW'(far_sum - (IW+1)'(mtbri_pkg::NWORDS)) : far_sum[IW-1:0];

  always_comb begin
    case (ctrl_i.rd_sel)
      mtbri_pkg::RD_CUR:  rd_addr = idx_q;
      mtbri_pkg::RD_NEXT: rd_addr = idx_next;
      mtbri_pkg::RD_FAR:  rd_addr = idx_far;
      default:            rd_addr = idx_q;
    endcase
  end

  assign seed_v   = ctrl_i.seed_cfg ? cfg_data_i : mtbri_pkg::DEFAULT_SEED;
  assign p_d      = mtbri_pkg::SEED_MULT * (p_q ^ (p_q >> 30)) + {22'd0, cnt_q};
  assign mixed    = mtbri_pkg::tw_mix(hi_q, lo_q, rd_q);
  assign tempered = mtbri_pkg::temper(mixed);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = mixed;
    if (ctrl_i.seed_start) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_v;
    end else if (ctrl_i.seed_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = p_d;
    end else if (ctrl_i.mix) begin
      wr_en   = 1'b1;
    end
  end

  // Seeding and draw index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.seed_start) begin
        idx_q <= '0;
        cnt_q <= IW'(1);
      end else if (ctrl_i.seed_step) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctrl_i.mix) begin
        idx_q <= idx_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.seed_start) p_q <= seed_v;
    else if (ctrl_i.seed_step) p_q <= p_d;
  end

  assign mag_w = span_q[30] ? 31'(-span_q) : span_q;
  always_comb begin
    smear = mag_w[29:0];
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q    <= bound_a_i;
      span_q <= 31'({bound_b_i[29], bound_b_i}) - 31'({bound_a_i[29], bound_a_i});
    end
    if (ctrl_i.span) begin
      mag_q  <= mag_w[29:0];
      mask_q <= smear;
      neg_q  <= span_q[30];
    end
    if (ctrl_i.cap_hi) hi_q <= rd_q;
    if (ctrl_i.cap_lo) lo_q <= rd_q;
    if (ctrl_i.load) r_q <= '0;
    else if (ctrl_i.mix) r_q <= tempered[29:0] & mask_q;
  end

  assign stat_o.seed_last = (cnt_q == mtbri_pkg::LAST_IDX);
  assign stat_o.span_zero = (span_q == '0);
  assign stat_o.reject    = (r_q > mag_q);

  assign off_w = neg_q ? -{2'b00, r_q} : {2'b00, r_q};
  assign sum_w = {{2{a_q[29]}}, a_q} + off_w;

  // Output register: hold the result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) value_q <= sum_w[30:0];
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

/* hdl/mt19937_bounded_random_int_top.sv */
`timescale 1ns / 1ps
// Top level of the bounded random integer source: controller plus datapath.
// Depends on mtbri_pkg, mtbri_ctrl and mtbri_dp.
//
// Usage:
//   Request channel (s_axis): one transfer carries bound_a and bound_b.
//   Result channel (m_axis): one transfer per request, value between the
//   bounds inclusive. Seed channel (cfg): a transfer reseeds the twister.
//   Seeding writes the 624-word state one word a cycle; while it runs,
//   neither requests nor seed writes are taken. After reset the state
//   is seeded with the default seed the same way.
//   A request with equal bounds makes no draw: it goes from the span step
//   to the done step, which loads the output register, and back to idle.
//   Otherwise each draw makes three reads through the single read port of
//   the state memory (current, next and far word), then the twist with
//   write-back and the tempering, then the range check. A draw outside the
//   span is redrawn; on average fewer than two draws are made per request.
//   The result waits in an output register; a stalled receiver holds it
//   and the next request finishes but waits in its last step until the
//   register is free.
module mt19937_bounded_random_int_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [29:0] bound_a, [59:30] bound_b, [63:60] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  mtbri_pkg::ctrl_t ctrl;
  mtbri_pkg::stat_t stat;
  logic             out_valid;
  logic [30:0]      value;

  mtbri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_i (out_valid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mtbri_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cfg_data_i  (cfg_data_i),
    .bound_a_i   (s_axis_tdata[29:0]),
    .bound_b_i   (s_axis_tdata[59:30]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_valid),
    .value_o     (value)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, value};

endmodule
